// File: design/rgb565_color_adjust_pipeline_defines.svh
// ----------------------------------------------------------------------------
// rgb565 color adjust pipeline assertion macros
// concurrent assertion forms for the pipeline top level design file
// ----------------------------------------------------------------------------
`ifndef RGB565_COLOR_ADJUST_PIPELINE_DEFINES_SVH
`define RGB565_COLOR_ADJUST_PIPELINE_DEFINES_SVH

// same-cycle implication
`define RCAP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcap assertion failed");

// next-cycle implication
`define RCAP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcap assertion failed");

`endif

// File: design/rcap_pkg.sv
// ----------------------------------------------------------------------------
// rcap package
// shared types and constants of the rgb565 color adjust pipeline
// ----------------------------------------------------------------------------
package rcap_pkg;

   typedef logic [7:0] chan_type;
   typedef chan_type [2:0] rgb_type;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLACK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAMMA    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CON_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TINT     = 3'd6;

   localparam logic [15:0] Q_ONE = 16'd4096;

   typedef struct packed {
      logic [7:0]  black;
      logic [7:0]  white;
      logic [15:0] gamma;
   } lvl_cfg_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } lvl_wr_type;

endpackage

// File: design/rcap_if.sv
// ----------------------------------------------------------------------------
// rcap channel interfaces
// valid/ready channels for pixel input, result output and register writes
// ----------------------------------------------------------------------------
interface rcap_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_word;
   modport source (output valid, output pixel_word, input ready);
   modport sink (input valid, input pixel_word, output ready);
endinterface

interface rcap_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rcap_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/rcap_ram.sv
// ----------------------------------------------------------------------------
// rcap ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rcap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/rcap_lvl_gen.sv
// ----------------------------------------------------------------------------
// rcap levels table generator
// sequencer that sweeps all 256 input codes through levels and gamma
// ----------------------------------------------------------------------------
module rcap_lvl_gen import rcap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lvl_cfg_type cfg,
   input  logic        touch,
   input  logic        enable,
   output lvl_wr_type  wr,
   output logic        ready
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_POW   = 3'd4;
   localparam logic [2:0] ST_RMUL  = 3'd5;
   localparam logic [2:0] ST_BMUL  = 3'd6;
   localparam logic [2:0] ST_WRITE = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic        ok_ff, ok_in;
   logic [7:0]  ent_ff, ent_in;
   logic [7:0]  rem_ff, rem_in;
   logic [31:0] x_ff, x_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  sq_ff, sq_in;
   logic [63:0] op_ff, op_in;
   logic [32:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] r_ff, r_in;
   logic        rone_ff, rone_in;
   logic [31:0] b_ff, b_in;
   logic [15:0] e_ff, e_in;
   logic [63:0] prod_ff, prod_in;
   logic [7:0]  res_ff, res_in;

   logic [7:0]  den;
   logic [7:0]  clip;
   logic [8:0]  dshift;
   logic [34:0] st;
   logic [34:0] trial;
   logic [31:0] new_root;
   logic [31:0] mul_a;
   logic [39:0] r255;

   assign den   = cfg.white - cfg.black;
   assign mul_a = (state_ff == ST_POW && e_ff[0]) ? r_ff : b_ff;
   assign r255  = {r_ff, 8'd0} - {8'd0, r_ff};

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      ent_in   = ent_ff;
      rem_in   = rem_ff;
      x_in     = x_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      op_in    = op_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      r_in     = r_ff;
      rone_in  = rone_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      clip     = ent_ff;
      dshift   = {rem_ff, 1'b0};
      st       = {srem_ff, op_ff[63:62]};
      trial    = {1'b0, root_ff, 2'b01};
      new_root = {root_ff[30:0], 1'b0};
      wr.en    = 1'b0;
      wr.addr  = ent_ff;
      wr.data  = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!ok_ff && enable) begin
               ent_in   = 8'd0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (cfg.white <= cfg.black) begin
               if (ent_ff > cfg.black) begin
                  res_in   = 8'd255;
                  state_in = ST_WRITE;
               end else begin
                  op_in    = 64'd0;
                  srem_in  = 33'd0;
                  root_in  = 32'd0;
                  cnt_in   = 5'd31;
                  sq_in    = 4'd0;
                  state_in = ST_SQRT;
               end
            end else begin
               if (ent_ff < cfg.black) begin
                  clip = cfg.black;
               end else if (ent_ff > cfg.white) begin
                  clip = cfg.white;
               end
               if (clip - cfg.black == den) begin
                  res_in   = 8'd255;
                  state_in = ST_WRITE;
               end else begin
                  rem_in   = clip - cfg.black;
                  cnt_in   = 5'd31;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // one quotient bit of (num << 32) / den per cycle
            if (dshift >= {1'b0, den}) begin
               rem_in = 8'(dshift - {1'b0, den});
               x_in   = {x_ff[30:0], 1'b1};
            end else begin
               rem_in = dshift[7:0];
               x_in   = {x_ff[30:0], 1'b0};
            end
            if (cnt_ff == 5'd0) begin
               op_in    = {x_in, 32'd0};
               srem_in  = 33'd0;
               root_in  = 32'd0;
               cnt_in   = 5'd31;
               sq_in    = 4'd0;
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_SQRT: begin
            // one root bit per cycle, twelve roots in a row
            if (st >= trial) begin
               srem_in  = 33'(st - trial);
               new_root = {root_ff[30:0], 1'b1};
            end else begin
               srem_in  = st[32:0];
            end
            root_in = new_root;
            op_in   = {op_ff[61:0], 2'b00};
            if (cnt_ff == 5'd0) begin
               if (sq_ff == 4'd11) begin
                  b_in     = new_root;
                  rone_in  = 1'b1;
                  r_in     = 32'd0;
                  e_in     = cfg.gamma;
                  state_in = ST_POW;
               end else begin
                  op_in   = {new_root, 32'd0};
                  srem_in = 33'd0;
                  root_in = 32'd0;
                  cnt_in  = 5'd31;
                  sq_in   = sq_ff + 4'd1;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_POW: begin
            prod_in = 64'(mul_a) * 64'(b_ff);
            if (e_ff == 16'd0) begin
               res_in   = rone_ff ? 8'd255 : r255[39:32];
               state_in = ST_WRITE;
            end else if (e_ff[0]) begin
               state_in = ST_RMUL;
            end else begin
               state_in = ST_BMUL;
            end
         end
         ST_RMUL: begin
            // r was exactly one: the product is b itself
            r_in     = rone_ff ? b_ff : prod_ff[63:32];
            rone_in  = 1'b0;
            prod_in  = 64'(b_ff) * 64'(b_ff);
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            b_in     = prod_ff[63:32];
            e_in     = {1'b0, e_ff[15:1]};
            state_in = ST_POW;
         end
         ST_WRITE: begin
            wr.en = 1'b1;
            if (ent_ff == 8'd255) begin
               ok_in    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ent_in   = ent_ff + 8'd1;
               state_in = ST_INIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a changed black, white or gamma restarts the sweep
      if (touch) begin
         ok_in    = 1'b0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      rem_ff  <= rem_in;
      x_ff    <= x_in;
      cnt_ff  <= cnt_in;
      sq_ff   <= sq_in;
      op_ff   <= op_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      r_ff    <= r_in;
      rone_ff <= rone_in;
      b_ff    <= b_in;
      e_ff    <= e_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign ready = ok_ff;
endmodule

// File: design/rcap_sat.sv
// ----------------------------------------------------------------------------
// rcap saturation
// hsl saturation change as a seven stage pipeline with a pipelined divider
// ----------------------------------------------------------------------------
module rcap_sat import rcap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  rgb_type     in_ch,
   input  logic [15:0] gain,
   output logic        out_valid,
   output rgb_type     out_ch
);
   typedef struct packed {
      logic [16:0] rem;
      logic [2:0]  q;
   } div_type;

   // three restoring division steps, divisor shifted by hi, hi-1, hi-2
   function automatic div_type div3(input logic [16:0] rem, input logic [7:0] d,
                                    input logic [3:0] hi);
      div_type     res;
      logic [16:0] dv;
      res.rem = rem;
      res.q   = 3'd0;
      for (int k = 0; k < 3; k++) begin
         dv = 17'(d) << (hi - 4'(k));
         if (res.rem >= dv) begin
            res.rem      = res.rem - dv;
            res.q[2 - k] = 1'b1;
         end
      end
      return res;
   endfunction

   // stage a: extremes and chroma times gain
   logic        a_valid_ff;
   rgb_type     a_ch_ff;
   logic [7:0]  a_mn_ff, a_d_ff, a_lim_ff;
   logic [8:0]  a_s_ff;
   logic [23:0] a_dg_ff;
   logic [7:0]  mx, mn;
   logic [8:0]  s_sum;

   always_comb begin
      mx = in_ch[0];
      mn = in_ch[0];
      for (int i = 1; i < 3; i++) begin
         if (in_ch[i] > mx) mx = in_ch[i];
         if (in_ch[i] < mn) mn = in_ch[i];
      end
      s_sum = 9'(mx) + 9'(mn);
   end

   // stage b: limited chroma and base
   logic        b_valid_ff;
   rgb_type     b_ch_ff;
   logic [7:0]  b_mn_ff, b_d_ff;
   logic [19:0] b_dq_ff;
   logic [20:0] b_base_ff;
   logic [19:0] lim12, dq;

   assign lim12 = {a_lim_ff, 12'd0};
   assign dq    = (a_dg_ff > 24'(lim12)) ? lim12 : a_dg_ff[19:0];

   // stage c: products
   logic        c_valid_ff;
   rgb_type     c_ch_ff;
   logic [7:0]  c_d_ff;
   logic [28:0] c_bd_ff;
   logic [27:0] c_pm_ff [3];

   // divider stages: index 0 holds the dividend, 1..3 the quotient steps
   logic        dv_valid_ff [4];
   rgb_type     dv_ch_ff    [4];
   logic [7:0]  dv_d_ff     [4];
   logic [16:0] dv_rem_ff   [4][3];
   logic [8:0]  dv_q_ff     [4][3];
   logic [30:0] n_sum       [3];
   div_type     step        [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_sum[i] = 31'(c_bd_ff) + {2'd0, c_pm_ff[i], 1'b0};
         for (int j = 0; j < 3; j++) begin
            step[j][i] = div3(dv_rem_ff[j][i], dv_d_ff[j], 4'(8 - 3 * j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         for (int j = 0; j < 4; j++) dv_valid_ff[j] <= 1'b0;
      end else if (en) begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         dv_valid_ff[0] <= c_valid_ff;
         for (int j = 1; j < 4; j++) dv_valid_ff[j] <= dv_valid_ff[j - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ch_ff   <= in_ch;
         a_mn_ff   <= mn;
         a_d_ff    <= mx - mn;
         a_s_ff    <= s_sum;
         a_lim_ff  <= (s_sum < 9'd255) ? s_sum[7:0] : 8'(9'd510 - s_sum);
         a_dg_ff   <= 24'(mx - mn) * 24'(gain);

         b_ch_ff   <= a_ch_ff;
         b_mn_ff   <= a_mn_ff;
         b_d_ff    <= a_d_ff;
         b_dq_ff   <= dq;
         b_base_ff <= {a_s_ff, 12'd0} - 21'(dq);

         c_ch_ff   <= b_ch_ff;
         c_d_ff    <= b_d_ff;
         c_bd_ff   <= 29'(b_base_ff) * 29'(b_d_ff);
         for (int i = 0; i < 3; i++) begin
            c_pm_ff[i] <= 28'(b_dq_ff) * 28'(b_ch_ff[i] - b_mn_ff);
         end

         dv_ch_ff[0] <= c_ch_ff;
         dv_d_ff[0]  <= c_d_ff;
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= n_sum[i][29:13];
            dv_q_ff[0][i]   <= 9'd0;
         end
         for (int j = 1; j < 4; j++) begin
            dv_ch_ff[j] <= dv_ch_ff[j - 1];
            dv_d_ff[j]  <= dv_d_ff[j - 1];
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[j][i] <= step[j - 1][i].rem;
               dv_q_ff[j][i]   <= {dv_q_ff[j - 1][i][5:0], step[j - 1][i].q};
            end
         end
      end
   end

   // grey pixels and unity gain pass through
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (gain == Q_ONE || dv_d_ff[3] == 8'd0) begin
            out_ch[i] = dv_ch_ff[3][i];
         end else if (dv_q_ff[3][i][8]) begin
            out_ch[i] = 8'd255;
         end else begin
            out_ch[i] = dv_q_ff[3][i][7:0];
         end
      end
   end

   assign out_valid = dv_valid_ff[3];
endmodule

// File: design/rcap_fin.sv
// ----------------------------------------------------------------------------
// rcap finish
// contrast about mid grey and white balance, ending in the result register
// ----------------------------------------------------------------------------
module rcap_fin import rcap_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rgb_type            in_ch,
   input  logic [15:0]        con_gain,
   input  logic signed [15:0] temp,
   input  logic signed [15:0] tint,
   output logic               out_valid,
   output rgb_type            out_ch
);
   function automatic logic [7:0] clamp_q12(input logic signed [26:0] t);
      logic [7:0] res;
      if (t < 0) begin
         res = 8'd0;
      end else if (t[25:12] > 14'd255) begin
         res = 8'd255;
      end else begin
         res = t[19:12];
      end
      return res;
   endfunction

   // stage p: contrast product
   logic               p_valid_ff;
   rgb_type            p_ch_ff;
   logic signed [25:0] p_prod_ff [3];
   logic signed [8:0]  diff      [3];

   // stage k: contrast result
   logic               k_valid_ff;
   rgb_type            k_ch_ff;
   rgb_type            con_ch;

   // stage o: result register
   logic               o_valid_ff;
   rgb_type            o_ch_ff;

   logic signed [22:0] tx, tw;
   logic signed [21:0] nx, nw;
   logic signed [26:0] tw27, nw27;
   logic signed [26:0] base27 [3];
   rgb_type            wb_ch;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed({1'b0, in_ch[i]}) - 9'sd128;
         if (con_gain == Q_ONE) begin
            con_ch[i] = p_ch_ff[i];
         end else begin
            con_ch[i] = clamp_q12($signed({p_prod_ff[i][25], p_prod_ff[i]}) + 27'sd526336);
         end
      end
   end

   // white balance offsets in q12
   assign tx   = {{7{temp[15]}}, temp};
   assign tw   = (tx <<< 6) - (tx <<< 2);
   assign nx   = {{6{tint[15]}}, tint};
   assign nw   = (nx <<< 4) + (nx <<< 2);
   assign tw27 = {{4{tw[22]}}, tw};
   assign nw27 = {{5{nw[21]}}, nw};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base27[i] = $signed({7'd0, k_ch_ff[i], 12'd0});
      end
      wb_ch[0] = clamp_q12(base27[0] + tw27 + nw27);
      wb_ch[1] = clamp_q12(base27[1] - (nw27 <<< 1));
      wb_ch[2] = clamp_q12(base27[2] - tw27 + nw27);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
         k_valid_ff <= p_valid_ff;
         o_valid_ff <= k_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ch_ff <= in_ch;
         for (int i = 0; i < 3; i++) begin
            p_prod_ff[i] <= diff[i] * $signed({1'b0, con_gain});
         end
         k_ch_ff <= con_ch;
         o_ch_ff <= wb_ch;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_ch    = o_ch_ff;
endmodule

// File: design/rgb565_color_adjust_pipeline.sv
// ----------------------------------------------------------------------------
// rgb565 color adjust pipeline
// rgb565 pixels through levels/gamma, saturation, contrast and white balance
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  req_bus   in   valid/ready           pixel_word[15:0] rgb565
//  rsp_bus   out  valid/ready           red[7:0] green[7:0] blue[7:0]
//  csr_bus   in   valid/ready (ready=1) index[2:0] data[15:0]
//
//  one pixel per clock through eleven register stages while the result is
//  not stalled and the table is current; the result leaves the last stage
//  levels and gamma come from a 256 entry table per channel, rebuilt by a
//  sequencer after a write to black, white or gamma: an entry may take a
//  divide, twelve square roots in a row and a power by squaring,
//  with req_bus.ready low while levels are on and the table is not current
//  synchronous active high reset; registers return to unity settings
//  a stalled result freezes the whole pipeline in place, nothing drops
// ----------------------------------------------------------------------------
`include "rgb565_color_adjust_pipeline_defines.svh"

module rgb565_color_adjust_pipeline import rcap_pkg::*; (
   input logic   clock,
   input logic   reset,
   rcap_req_if.sink   req_bus,
   rcap_rsp_if.source rsp_bus,
   rcap_csr_if.sink   csr_bus
);
   // register file
   logic [7:0]         black_ff, white_ff;
   logic [15:0]        gamma_ff, sat_gain_ff, con_gain_ff;
   logic signed [15:0] temp_ff, tint_ff;
   logic               csr_wr;
   logic               touch;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;
   assign touch         = csr_wr && (csr_bus.index == REG_BLACK ||
                                     csr_bus.index == REG_WHITE ||
                                     csr_bus.index == REG_GAMMA);

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff    <= 8'd0;
         white_ff    <= 8'd255;
         gamma_ff    <= Q_ONE;
         sat_gain_ff <= Q_ONE;
         con_gain_ff <= Q_ONE;
         temp_ff     <= 16'sd0;
         tint_ff     <= 16'sd0;
      end else if (csr_wr) begin
         unique case (csr_bus.index)
            REG_BLACK:    black_ff    <= csr_bus.data[7:0];
            REG_WHITE:    white_ff    <= csr_bus.data[7:0];
            REG_GAMMA:    gamma_ff    <= csr_bus.data;
            REG_SAT_GAIN: sat_gain_ff <= csr_bus.data;
            REG_CON_GAIN: con_gain_ff <= csr_bus.data;
            REG_TEMP:     temp_ff     <= $signed(csr_bus.data);
            REG_TINT:     tint_ff     <= $signed(csr_bus.data);
            default: begin
            end
         endcase
      end
   end

   // levels table
   lvl_cfg_type lvl_cfg;
   lvl_wr_type  lvl_wr;
   logic        tbl_ok;
   logic        lvl_en;

   assign lvl_cfg.black = black_ff;
   assign lvl_cfg.white = white_ff;
   assign lvl_cfg.gamma = gamma_ff;
   assign lvl_en        = gamma_ff != Q_ONE || black_ff != 8'd0 || white_ff != 8'd255;

   rcap_lvl_gen u_lvl_gen (
      .clock  (clock),
      .reset  (reset),
      .cfg    (lvl_cfg),
      .touch  (touch),
      .enable (lvl_en),
      .wr     (lvl_wr),
      .ready  (tbl_ok)
   );

   // stall control: everything moves when the result slot is free or taken
   logic    advance;
   logic    fin_valid;
   rgb_type fin_ch;

   assign advance       = !fin_valid || rsp_bus.ready;
   assign req_bus.ready = advance && (!lvl_en || tbl_ok);

   // bit replication to 8 bits
   rgb_type ex_ch;
   assign ex_ch[0] = {req_bus.pixel_word[15:11], req_bus.pixel_word[15:13]};
   assign ex_ch[1] = {req_bus.pixel_word[10:5], req_bus.pixel_word[10:9]};
   assign ex_ch[2] = {req_bus.pixel_word[4:0], req_bus.pixel_word[4:2]};

   // stage 1: table read alongside the expanded pixel
   rgb_type lv_ch;
   rgb_type s1_ch_ff;
   logic    s1_valid_ff;
   rgb_type s1_ch;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rcap_ram #(
         .WIDTH (8),
         .DEPTH (256)
      ) u_tbl (
         .clock   (clock),
         .wr_en   (lvl_wr.en),
         .wr_addr (lvl_wr.addr),
         .wr_data (lvl_wr.data),
         .rd_en   (advance),
         .rd_addr (ex_ch[g]),
         .rd_data (lv_ch[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid && req_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ch_ff <= ex_ch;
      end
   end

   assign s1_ch = lvl_en ? lv_ch : s1_ch_ff;

   // saturation, stages 2 to 8
   logic    sat_valid;
   rgb_type sat_ch;

   rcap_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s1_valid_ff),
      .in_ch     (s1_ch),
      .gain      (sat_gain_ff),
      .out_valid (sat_valid),
      .out_ch    (sat_ch)
   );

   // contrast and white balance, stages 9 to 11
   rcap_fin u_fin (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (sat_valid),
      .in_ch     (sat_ch),
      .con_gain  (con_gain_ff),
      .temp      (temp_ff),
      .tint      (tint_ff),
      .out_valid (fin_valid),
      .out_ch    (fin_ch)
   );

   assign rsp_bus.valid = fin_valid;
   assign rsp_bus.red   = fin_ch[0];
   assign rsp_bus.green = fin_ch[1];
   assign rsp_bus.blue  = fin_ch[2];

   // no pixel enters through a stale table
   `RCAP_ASSERT_IMP(a_tbl_current, clock, reset, req_bus.valid && req_bus.ready && lvl_en, tbl_ok)
   // a levels setting change invalidates the table
   `RCAP_ASSERT_NEXT(a_touch_drops, clock, reset, touch, !tbl_ok)
   // the sweep never writes over a finished table
   `RCAP_ASSERT_IMP(a_wr_sweep, clock, reset, lvl_wr.en, !tbl_ok)
endmodule
